// File: hdl/smi_pkg.sv
// Shared constants and register codes for the small matrix inverse block.
// No dependencies.
package smi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SIZE_WIDTH     = 2;
  localparam int THR_WIDTH      = 31;
  localparam int CFG_IDX_WIDTH  = 8;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_MATRIX_SIZE = 8'd0,
    REG_SING_THR    = 8'd1
  } cfg_reg_e;

endpackage

// File: hdl/smi_cofactor.sv
// Two-stage cofactor unit: 2x2 minor products, then the adjugate for order 1..3.
// Depends on smi_pkg.
module smi_cofactor import smi_pkg::*; #(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [SIZE_WIDTH-1:0]         size_i,
  input  logic signed [W-1:0]           elem_i [9],
  output logic                          valid_o,
  output logic [SIZE_WIDTH-1:0]         size_o,
  output logic signed [W-1:0]           row0_o [3],
  output logic signed [2*W:0]           adj_o  [9]
);

  logic                  valid1_q;
  logic [SIZE_WIDTH-1:0] size1_q;
  logic signed [W-1:0]   elem1_q [9];
  logic signed [2*W-1:0] pa_q [9];
  logic signed [2*W-1:0] pb_q [9];

  logic                  valid2_q;
  logic [SIZE_WIDTH-1:0] size2_q;
  logic signed [W-1:0]   row0_q [3];
  logic signed [2*W:0]   adj_d  [9];
  logic signed [2*W:0]   adj_q  [9];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;

      always_ff @(posedge clk_i) begin
        pa_q[i*3+j] <= elem_i[R0*3+C0] * elem_i[R1*3+C1];
        pb_q[i*3+j] <= elem_i[R0*3+C1] * elem_i[R1*3+C0];
      end

      // adjugate entry (j,i) is cofactor (i,j)
      always_comb begin
        logic signed [2*W:0] c;
        c = '0;
        case (size1_q)
          2'd3: c = (2*W+1)'(pa_q[i*3+j]) - (2*W+1)'(pb_q[i*3+j]);
          2'd2: begin
            if (i < 2 && j < 2) begin
              c = (2*W+1)'(elem1_q[(1-i)*3 + (1-j)]);
            end
          end
          default: begin
            if (i == 0 && j == 0) begin
              c = (2*W+1)'(1);
            end
          end
        endcase
        adj_d[j*3+i] = ((i + j) % 2 == 1) ? -c : c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size1_q   <= size_i;
    elem1_q   <= elem_i;
    size2_q   <= size1_q;
    row0_q[0] <= elem1_q[0];
    row0_q[1] <= elem1_q[1];
    row0_q[2] <= elem1_q[2];
    adj_q     <= adj_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign size_o  = size2_q;
  assign row0_o  = row0_q;
  assign adj_o   = adj_q;

endmodule

// File: hdl/smi_det.sv
// Three-stage determinant unit: split products, sum, then magnitude, singular
// test, determinant saturation and numerator forming. Depends on smi_pkg.
module smi_det import smi_pkg::*; #(
  parameter int W   = DATA_WIDTH_DEF,
  parameter int F   = FRAC_BITS_DEF,
  parameter int DTW = 3*W + 2,
  parameter int NW  = 2*W + 1 + 2*F
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [SIZE_WIDTH-1:0] size_i,
  input  logic [THR_WIDTH-1:0]  thr_i,
  input  logic signed [W-1:0]   row0_i [3],
  input  logic signed [2*W:0]   adj_i  [9],
  output logic                  valid_o,
  output logic signed [W-1:0]   det_out_o,
  output logic                  singular_o,
  output logic [DTW-1:0]        den_o,
  output logic [NW-1:0]         num_o [9],
  output logic [8:0]            neg_o
);

  localparam int TW = THR_WIDTH + 2*F;
  localparam int XT = (DTW > TW) ? DTW : TW;
  localparam logic [DTW-1:0] LIM = DTW'(1) << (W-1);

  logic                    valid3_q, valid4_q, valid5_q;
  logic [SIZE_WIDTH-1:0]   size3_q, size4_q;
  logic signed [2*W:0]     pl_q [3];
  logic signed [2*W:0]     ph_q [3];
  logic signed [2*W:0]     adj3_q [9];
  logic signed [2*W:0]     adj4_q [9];
  logic signed [DTW-1:0]   det_d, det_q;

  logic [DTW-1:0]          mag;
  logic [DTW-1:0]          mag_sh;
  logic [XT-1:0]           thr_sh;
  logic signed [W-1:0]     det_out_d, det_out_q;
  logic                    sing_q;
  logic [DTW-1:0]          den_q;
  logic [NW-1:0]           num_d [9];
  logic [NW-1:0]           num_q [9];
  logic [8:0]              neg_d, neg_q;

  // stage 3: row-0 element times adjugate column 0, cut in two halves
  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk_i) begin
      pl_q[j] <= row0_i[j] * $signed({1'b0, adj_i[j*3][W-1:0]});
      ph_q[j] <= row0_i[j] * $signed(adj_i[j*3][2*W:W]);
    end
  end

  // stage 4: sum
  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DTW'(ph_q[j]) <<< W) + DTW'(pl_q[j]);
    end
  end

  // stage 5
  always_comb begin
    mag = det_q[DTW-1] ? DTW'(-det_q) : DTW'(det_q);
    case (size4_q)
      2'd3: begin
        mag_sh = mag >> (2*F);
        thr_sh = XT'(thr_i) << (2*F);
      end
      2'd2: begin
        mag_sh = mag >> F;
        thr_sh = XT'(thr_i) << F;
      end
      default: begin
        mag_sh = mag;
        thr_sh = XT'(thr_i);
      end
    endcase
    if (det_q[DTW-1]) begin
      det_out_d = (mag_sh > LIM) ? {1'b1, {(W-1){1'b0}}} : -W'(mag_sh);
    end else begin
      det_out_d = (mag_sh > LIM - 1'b1) ? {1'b0, {(W-1){1'b1}}} : W'(mag_sh);
    end
    for (int k = 0; k < 9; k++) begin
      num_d[k] = NW'(adj4_q[k][2*W] ? -adj4_q[k] : adj4_q[k]) << (2*F);
      neg_d[k] = adj4_q[k][2*W] ^ det_q[DTW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    size3_q   <= size_i;
    adj3_q    <= adj_i;
    size4_q   <= size3_q;
    adj4_q    <= adj3_q;
    det_q     <= det_d;
    det_out_q <= det_out_d;
    sing_q    <= XT'(mag) <= thr_sh;
    den_q     <= mag;
    num_q     <= num_d;
    neg_q     <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
      valid5_q <= valid4_q;
    end
  end

  assign valid_o    = valid5_q;
  assign det_out_o  = det_out_q;
  assign singular_o = sing_q;
  assign den_o      = den_q;
  assign num_o      = num_q;
  assign neg_o      = neg_q;

endmodule

// File: hdl/smi_div.sv
// Pipelined restoring divider lane, one quotient bit per stage, with
// overflow precheck and signed saturation. Depends on smi_pkg.
module smi_div import smi_pkg::*; #(
  parameter int W   = DATA_WIDTH_DEF,
  parameter int NW  = 2*W + 1 + 2*FRAC_BITS_DEF,
  parameter int DTW = 3*W + 2
) (
  input  logic                clk_i,
  input  logic [NW-1:0]       num_i,
  input  logic [DTW-1:0]      den_i,
  input  logic                neg_i,
  input  logic                kill_i,
  output logic signed [W-1:0] quo_o
);

  localparam int XW = (NW > DTW + W) ? NW : DTW + W;

  logic [XW-1:0]  rem_q  [W+1];
  logic [DTW-1:0] den_q  [W+1];
  logic [W-1:0]   quo_q  [W+1];
  logic           neg_q  [W+1];
  logic           kill_q [W+1];
  logic           big_q  [W+1];
  logic signed [W-1:0] res_d, res_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= XW'(num_i);
    den_q[0]  <= den_i;
    quo_q[0]  <= '0;
    neg_q[0]  <= neg_i;
    kill_q[0] <= kill_i;
    big_q[0]  <= XW'(num_i) >= (XW'(den_i) << W);
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int B = W - 1 - s;
    logic [XW:0] trial;
    assign trial = {1'b0, rem_q[s]} - ({1'b0, XW'(den_q[s])} << B);
    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= trial[XW] ? rem_q[s] : trial[XW-1:0];
      quo_q[s+1]  <= quo_q[s] | (W'(!trial[XW]) << B);
      den_q[s+1]  <= den_q[s];
      neg_q[s+1]  <= neg_q[s];
      kill_q[s+1] <= kill_q[s];
      big_q[s+1]  <= big_q[s];
    end
  end

  always_comb begin
    if (kill_q[W]) begin
      res_d = '0;
    end else if (neg_q[W]) begin
      res_d = (big_q[W] || quo_q[W] > {1'b1, {(W-1){1'b0}}}) ?
              {1'b1, {(W-1){1'b0}}} : -quo_q[W];
    end else begin
      res_d = (big_q[W] || quo_q[W][W-1]) ? {1'b0, {(W-1){1'b1}}} : quo_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign quo_o = res_q;

endmodule

// File: hdl/small_matrix_inverse_det.sv
// Start to done passes two cofactor stages, three determinant stages and
// DATA_WIDTH + 2 divider stages.
// Throughput: one matrix per cycle; busy stays low and nothing stalls.
// Reset clears all valid bits, sets matrix_size to 3 and the threshold to 0.
// Depends on smi_pkg, smi_cofactor, smi_det, smi_div.
module small_matrix_inverse_det import smi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] a00_i, a01_i, a02_i,
  input  logic signed [DATA_WIDTH-1:0] a10_i, a11_i, a12_i,
  input  logic signed [DATA_WIDTH-1:0] a20_i, a21_i, a22_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]     cfg_index_i,
  input  logic [THR_WIDTH-1:0]         cfg_data_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] inv00_o, inv01_o, inv02_o,
  output logic signed [DATA_WIDTH-1:0] inv10_o, inv11_o, inv12_o,
  output logic signed [DATA_WIDTH-1:0] inv20_o, inv21_o, inv22_o,
  output logic signed [DATA_WIDTH-1:0] det_out_o,
  output logic                         singular_o
);

  localparam int W   = DATA_WIDTH;
  localparam int DTW = 3*W + 2;
  localparam int NW  = 2*W + 1 + 2*FRAC_BITS;
  localparam int DL  = W + 2;

  logic [SIZE_WIDTH-1:0] size_q;
  logic [THR_WIDTH-1:0]  thr_q;
  logic [SIZE_WIDTH-1:0] size_eff;
  logic signed [W-1:0]   elem [9];

  logic                  cof_valid;
  logic [SIZE_WIDTH-1:0] cof_size;
  logic signed [W-1:0]   row0 [3];
  logic signed [2*W:0]   adj  [9];

  logic                  det_valid;
  logic signed [W-1:0]   det_out;
  logic                  sing;
  logic [DTW-1:0]        den;
  logic [NW-1:0]         num [9];
  logic [8:0]            neg;
  logic signed [W-1:0]   inv [9];

  logic                  vld_q  [DL];
  logic signed [W-1:0]   dout_q [DL];
  logic                  sing_q [DL];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_WIDTH'(3);
      thr_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MATRIX_SIZE: size_q <= cfg_data_i[SIZE_WIDTH-1:0];
        REG_SING_THR:    thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign size_eff = (size_q == '0) ? SIZE_WIDTH'(1) : size_q;
  assign elem = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  smi_cofactor #(.W(W)) u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .size_i  (size_eff),
    .elem_i  (elem),
    .valid_o (cof_valid),
    .size_o  (cof_size),
    .row0_o  (row0),
    .adj_o   (adj)
  );

  smi_det #(.W(W), .F(FRAC_BITS), .DTW(DTW), .NW(NW)) u_det (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cof_valid),
    .size_i     (cof_size),
    .thr_i      (thr_q),
    .row0_i     (row0),
    .adj_i      (adj),
    .valid_o    (det_valid),
    .det_out_o  (det_out),
    .singular_o (sing),
    .den_o      (den),
    .num_o      (num),
    .neg_o      (neg)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    smi_div #(.W(W), .NW(NW), .DTW(DTW)) u_div (
      .clk_i  (clk_i),
      .num_i  (num[k]),
      .den_i  (den),
      .neg_i  (neg[k]),
      .kill_i (sing),
      .quo_o  (inv[k])
    );
  end

  always_ff @(posedge clk_i) begin
    dout_q[0] <= det_out;
    sing_q[0] <= sing;
    for (int s = 1; s < DL; s++) begin
      dout_q[s] <= dout_q[s-1];
      sing_q[s] <= sing_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DL; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= det_valid;
      for (int s = 1; s < DL; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  assign done_o     = vld_q[DL-1];
  assign det_out_o  = dout_q[DL-1];
  assign singular_o = sing_q[DL-1];
  assign inv00_o = inv[0];
  assign inv01_o = inv[1];
  assign inv02_o = inv[2];
  assign inv10_o = inv[3];
  assign inv11_o = inv[4];
  assign inv12_o = inv[5];
  assign inv20_o = inv[6];
  assign inv21_o = inv[7];
  assign inv22_o = inv[8];

endmodule
